@@ hw/rtl/lfmc_pkg.sv @@
// shared types, codes and constants of the line follower mode controller
package lfmc_pkg;

    // default sensor channel count
    localparam int DEF_CHANNELS = 5;
    // position weight per channel
    localparam int POS_PER_CHANNEL = 1000;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_HOLD = 2'd0;
    localparam logic [1:0] CFG_STOP_BAR  = 2'd1;
    localparam logic [1:0] CFG_CLEAR     = 2'd2;

    // configuration reset values
    localparam logic [15:0] RST_LINE_HOLD = 16'd200;
    localparam logic [15:0] RST_STOP_BAR  = 16'd150;
    localparam logic [15:0] RST_CLEAR     = 16'd500;

    // request kinds
    localparam logic [1:0] KIND_FRAME  = 2'd0;
    localparam logic [1:0] KIND_IDLE   = 2'd1;
    localparam logic [1:0] KIND_RESUME = 2'd2;

    // drive codes
    localparam logic [1:0] DRV_COAST    = 2'd0;
    localparam logic [1:0] DRV_BRAKE    = 2'd1;
    localparam logic [1:0] DRV_STRAIGHT = 2'd2;
    localparam logic [1:0] DRV_STEER    = 2'd3;

    // status codes
    localparam logic [2:0] ST_WAITING   = 3'd0;
    localparam logic [2:0] ST_LOW_BATT  = 3'd1;
    localparam logic [2:0] ST_ARMING    = 3'd2;
    localparam logic [2:0] ST_FOLLOWING = 3'd3;
    localparam logic [2:0] ST_UNARMED   = 3'd4;
    localparam logic [2:0] ST_CONFIRM   = 3'd5;
    localparam logic [2:0] ST_FINISHED  = 3'd6;
    localparam logic [2:0] ST_IDLE      = 3'd7;

    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_FOLLOW = 2'd1,
        MODE_FINISH = 2'd2,
        MODE_HALT   = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        line_found;
        logic [11:0] line_position;
        logic        all_black;
        logic        nothing_seen;
        logic        supply_low;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         mode;
        logic [1:0]         drive;
        logic [2:0]         status;
        logic signed [11:0] line_error;
        logic               steer_reset;
    } t_out_item;

    typedef struct packed {
        logic [15:0] line_hold_time;
        logic [15:0] stop_bar_time;
        logic [15:0] clear_time;
    } t_cfg;

    typedef struct packed {
        t_mode              mode;
        logic               line_seen;
        logic [31:0]        line_since;
        logic               clear_active;
        logic [31:0]        clear_since;
        logic               stop_armed;
        logic               black_active;
        logic [31:0]        black_since;
        logic signed [11:0] error;
    } t_state;

endpackage

@@ hw/rtl/lfmc_step.sv @@
// next-state and result logic for one control frame
module lfmc_step #(
    parameter int CHANNELS = lfmc_pkg::DEF_CHANNELS
) (
    input  lfmc_pkg::t_state   i_state,
    input  lfmc_pkg::t_cfg     i_cfg,
    input  lfmc_pkg::t_in_item i_item,
    output lfmc_pkg::t_state   o_state,
    output lfmc_pkg::t_out_item o_result
);
    import lfmc_pkg::*;

    localparam int CENTER = (CHANNELS - 1) * POS_PER_CHANNEL / 2;

    logic signed [15:0] diff;
    logic signed [11:0] err_now;
    logic [31:0]        line_ref;
    logic [31:0]        black_ref;
    logic [31:0]        clear_ref;
    t_state             s;
    t_mode              m_cmd;
    logic               sreset;
    logic [1:0]         drive;
    logic [2:0]         status;

    // line error with saturation to the 12-bit range
    always_comb begin
        diff = $signed({4'b0000, i_item.line_position}) - $signed(16'(CENTER));
        if (!i_item.line_found) begin
            err_now = '0;
        end else if (diff > 16'sd2047) begin
            err_now = 12'sd2047;
        end else if (diff < -16'sd2048) begin
            err_now = -12'sd2048;
        end else begin
            err_now = diff[11:0];
        end
    end

    // command handling followed by the per-mode frame handling
    always_comb begin
        s      = i_state;
        sreset = 1'b0;
        drive  = DRV_COAST;
        status = ST_WAITING;
        if (i_item.kind == KIND_IDLE) begin
            s.mode = MODE_HALT;
            sreset = 1'b1;
        end else if (i_item.kind == KIND_RESUME) begin
            s.mode         = MODE_WAIT;
            s.line_seen    = 1'b0;
            s.clear_active = 1'b0;
            s.black_active = 1'b0;
            s.stop_armed   = 1'b0;
            sreset         = 1'b1;
        end
        m_cmd     = s.mode;
        line_ref  = s.line_seen ? s.line_since : i_item.now_ms;
        black_ref = s.black_active ? s.black_since : i_item.now_ms;
        clear_ref = s.clear_active ? s.clear_since : i_item.now_ms;

        case (m_cmd)
            MODE_WAIT: begin
                drive   = DRV_COAST;
                s.error = err_now;
                if (i_item.supply_low) begin
                    status      = ST_LOW_BATT;
                    s.line_seen = 1'b0;
                end else if (!i_item.line_found) begin
                    status      = ST_WAITING;
                    s.line_seen = 1'b0;
                end else begin
                    s.line_seen  = 1'b1;
                    s.line_since = line_ref;
                    if ((i_item.now_ms - line_ref) >= {16'd0, i_cfg.line_hold_time}) begin
                        s.mode         = MODE_FOLLOW;
                        s.black_active = 1'b0;
                        s.stop_armed   = 1'b0;
                        s.error        = '0;
                        sreset         = 1'b1;
                        status         = ST_FOLLOWING;
                    end else begin
                        status = ST_ARMING;
                    end
                end
            end
            MODE_FOLLOW: begin
                if (i_item.all_black) begin
                    if (!s.stop_armed) begin
                        drive          = DRV_STRAIGHT;
                        status         = ST_UNARMED;
                        s.black_active = 1'b0;
                    end else begin
                        s.black_active = 1'b1;
                        s.black_since  = black_ref;
                        if ((i_item.now_ms - black_ref) >= {16'd0, i_cfg.stop_bar_time}) begin
                            s.mode         = MODE_FINISH;
                            s.clear_active = 1'b0;
                            drive          = DRV_BRAKE;
                            status         = ST_FINISHED;
                        end else begin
                            drive  = DRV_STRAIGHT;
                            status = ST_CONFIRM;
                        end
                    end
                end else begin
                    s.black_active = 1'b0;
                    s.stop_armed   = 1'b1;
                    drive          = DRV_STEER;
                    status         = ST_FOLLOWING;
                end
            end
            MODE_FINISH: begin
                drive  = DRV_BRAKE;
                status = ST_FINISHED;
                if (!i_item.nothing_seen) begin
                    s.clear_active = 1'b0;
                end else begin
                    s.clear_active = 1'b1;
                    s.clear_since  = clear_ref;
                    if ((i_item.now_ms - clear_ref) >= {16'd0, i_cfg.clear_time}) begin
                        s.mode         = MODE_WAIT;
                        s.line_seen    = 1'b0;
                        s.clear_active = 1'b0;
                        s.black_active = 1'b0;
                        s.stop_armed   = 1'b0;
                        sreset         = 1'b1;
                        drive          = DRV_COAST;
                        status         = ST_WAITING;
                    end
                end
            end
            default: begin
                // manual stop
                drive   = DRV_COAST;
                status  = ST_IDLE;
                s.error = err_now;
            end
        endcase

        o_state              = s;
        o_result.mode        = s.mode;
        o_result.drive       = drive;
        o_result.status      = status;
        o_result.line_error  = s.error;
        o_result.steer_reset = sreset;
    end

endmodule

@@ hw/rtl/line_follower_mode_controller.sv @@
// line follower mode controller top level: request and result registers
//
// channel  | direction | handshake             | payload
// request  | in        | i_in_valid/o_in_ready | i_in_item  (t_in_item)
// result   | out       | o_out_valid/i_out_ready | o_out_item (t_out_item)
// config   | in        | i_cfg_we, no wait     | i_cfg_idx, i_cfg_data
//
// a request is captured in the request register, evaluated combinationally and
// written to the result register with the mode state; one request per cycle
// is sustained while results are taken
// the evaluation stage moves only when the result register is free or emptied
// synchronous active-low reset clears both stages, the mode state and restores
// the configuration defaults
module line_follower_mode_controller #(
    parameter int CHANNELS = lfmc_pkg::DEF_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lfmc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lfmc_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data
);
    import lfmc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_cfg      r_cfg;
    t_state    n_state;
    t_out_item n_result;
    logic      adv;

    // stage advance and request acceptance
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_hold_time <= RST_LINE_HOLD;
            r_cfg.stop_bar_time  <= RST_STOP_BAR;
            r_cfg.clear_time     <= RST_CLEAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_HOLD: r_cfg.line_hold_time <= i_cfg_data;
                CFG_STOP_BAR:  r_cfg.stop_bar_time  <= i_cfg_data;
                CFG_CLEAR:     r_cfg.clear_time     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    // frame evaluation
    lfmc_step #(
        .CHANNELS (CHANNELS)
    ) u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // mode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_WAIT;
            r_state.line_seen    <= 1'b0;
            r_state.line_since   <= '0;
            r_state.clear_active <= 1'b0;
            r_state.clear_since  <= '0;
            r_state.stop_armed   <= 1'b0;
            r_state.black_active <= 1'b0;
            r_state.black_since  <= '0;
            r_state.error        <= '0;
        end else if (adv) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hw/rtl/lfmc_checker.sv @@
// port-level checks of the line follower mode controller and their binding
module lfmc_port_checks (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lfmc_pkg::t_out_item o_out_item
);
    import lfmc_pkg::*;

    // a finished status always comes with the finished mode and braking
    a_finish_brakes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == ST_FINISHED
        |-> o_out_item.mode == MODE_FINISH && o_out_item.drive == DRV_BRAKE)
        else $error("finished status without finished mode and brake");

    // idle mode only coasts with idle status
    a_idle_coasts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.mode == MODE_HALT
        |-> o_out_item.status == ST_IDLE && o_out_item.drive == DRV_COAST)
        else $error("idle mode with wrong status or drive");

    // coasting in following only happens at the start, which resets steering
    a_follow_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.mode == MODE_FOLLOW && o_out_item.drive == DRV_COAST
        |-> o_out_item.steer_reset && o_out_item.line_error == 12'sd0
            && o_out_item.status == ST_FOLLOWING)
        else $error("start of following without steer reset or cleared error");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

endmodule

bind line_follower_mode_controller lfmc_port_checks u_lfmc_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

@@ tb/lfmc_checker.sv @@
// checker for the line follower mode controller: mode prediction and result compare
`timescale 1ns / 1ps
module lfmc_checker #(
    parameter int CHANNELS = lfmc_pkg::DEF_CHANNELS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  lfmc_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  lfmc_pkg::t_out_item i_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output int                  o_mismatches,
    output int                  o_pending
);
    import lfmc_pkg::*;

    localparam int CENTER       = (CHANNELS - 1) * POS_PER_CHANNEL / 2;
    localparam int ERR_MAX      = 2047;
    localparam int ERR_MIN      = -2048;

    t_cfg      timing;
    t_state    ctl;
    t_out_item mode_outputs_due[$];
    int        bad_count  = 0;
    int        result_seq = 0;

    // signed distance of the line from the array center, clamped to 12 bits
    function automatic logic signed [11:0] center_offset(input logic found,
                                                         input logic [11:0] pos);
        int diff;
        diff = int'(pos) - CENTER;
        if (!found) diff = 0;
        else if (diff > ERR_MAX) diff = ERR_MAX;
        else if (diff < ERR_MIN) diff = ERR_MIN;
        return diff[11:0];
    endfunction

    // drop every timer and the stop arming, back to waiting
    task automatic clear_to_waiting();
        ctl.mode         = MODE_WAIT;
        ctl.line_seen    = 1'b0;
        ctl.clear_active = 1'b0;
        ctl.black_active = 1'b0;
        ctl.stop_armed   = 1'b0;
    endtask

    // one control frame of the mode machine
    task automatic step_mode_controller(input t_in_item req, output t_out_item res);
        logic [1:0]  drv;
        logic [2:0]  sts;
        logic        srst;
        logic [31:0] held;
        drv  = DRV_COAST;
        sts  = ST_WAITING;
        srst = 1'b0;
        // console command acts before the frame
        if (req.kind == KIND_IDLE) begin
            ctl.mode = MODE_HALT;
            srst     = 1'b1;
        end else if (req.kind == KIND_RESUME) begin
            clear_to_waiting();
            srst = 1'b1;
        end
        case (ctl.mode)
            MODE_WAIT: begin
                ctl.error = center_offset(req.line_found, req.line_position);
                if (req.supply_low) begin
                    sts           = ST_LOW_BATT;
                    ctl.line_seen = 1'b0;
                end else if (!req.line_found) begin
                    ctl.line_seen = 1'b0;
                end else begin
                    if (!ctl.line_seen) begin
                        ctl.line_seen  = 1'b1;
                        ctl.line_since = req.now_ms;
                    end
                    held = req.now_ms - ctl.line_since;
                    // line held long enough: start following
                    if (held >= {16'd0, timing.line_hold_time}) begin
                        ctl.mode         = MODE_FOLLOW;
                        ctl.black_active = 1'b0;
                        ctl.stop_armed   = 1'b0;
                        ctl.error        = '0;
                        srst             = 1'b1;
                        sts              = ST_FOLLOWING;
                    end else begin
                        sts = ST_ARMING;
                    end
                end
            end
            MODE_FOLLOW: begin
                if (req.all_black) begin
                    if (!ctl.stop_armed) begin
                        drv              = DRV_STRAIGHT;
                        sts              = ST_UNARMED;
                        ctl.black_active = 1'b0;
                    end else begin
                        if (!ctl.black_active) begin
                            ctl.black_active = 1'b1;
                            ctl.black_since  = req.now_ms;
                        end
                        held = req.now_ms - ctl.black_since;
                        // stop bar confirmed
                        if (held >= {16'd0, timing.stop_bar_time}) begin
                            ctl.mode         = MODE_FINISH;
                            ctl.clear_active = 1'b0;
                            drv              = DRV_BRAKE;
                            sts              = ST_FINISHED;
                        end else begin
                            drv = DRV_STRAIGHT;
                            sts = ST_CONFIRM;
                        end
                    end
                end else begin
                    ctl.black_active = 1'b0;
                    ctl.stop_armed   = 1'b1;
                    drv              = DRV_STEER;
                    sts              = ST_FOLLOWING;
                end
            end
            MODE_FINISH: begin
                drv = DRV_BRAKE;
                sts = ST_FINISHED;
                if (!req.nothing_seen) begin
                    ctl.clear_active = 1'b0;
                end else begin
                    if (!ctl.clear_active) begin
                        ctl.clear_active = 1'b1;
                        ctl.clear_since  = req.now_ms;
                    end
                    held = req.now_ms - ctl.clear_since;
                    // track clear long enough: back to waiting
                    if (held >= {16'd0, timing.clear_time}) begin
                        clear_to_waiting();
                        srst = 1'b1;
                        drv  = DRV_COAST;
                        sts  = ST_WAITING;
                    end
                end
            end
            default: begin
                sts       = ST_IDLE;
                ctl.error = center_offset(req.line_found, req.line_position);
            end
        endcase
        res.mode        = ctl.mode;
        res.drive       = drv;
        res.status      = sts;
        res.line_error  = ctl.error;
        res.steer_reset = srst;
    endtask

    // one line per bad result, count all of them
    task automatic report_mismatch(input string what, input t_out_item got,
                                   input t_out_item want);
        bad_count = bad_count + 1;
        $display("%0t result %0d %s: got m%0d d%0d s%0d e%0d r%0d %s",
                 $realtime, result_seq, what,
                 got.mode, got.drive, got.status, $signed(got.line_error),
                 got.steer_reset,
                 $sformatf("want m%0d d%0d s%0d e%0d r%0d",
                           want.mode, want.drive, want.status,
                           $signed(want.line_error), want.steer_reset));
    endtask

    // watch config writes, results and requests on every edge
    always @(posedge i_clk) begin : watch
        t_out_item got;
        t_out_item want;
        t_out_item predicted;
        if (!i_rst_n) begin
            timing.line_hold_time = RST_LINE_HOLD;
            timing.stop_bar_time  = RST_STOP_BAR;
            timing.clear_time     = RST_CLEAR;
            ctl                   = '0;
            ctl.mode              = MODE_WAIT;
            mode_outputs_due.delete();
        end else begin
            // the user must make register writes only while the block is idle; the block itself does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_HOLD: timing.line_hold_time = i_cfg_data;
                    CFG_STOP_BAR:  timing.stop_bar_time  = i_cfg_data;
                    CFG_CLEAR:     timing.clear_time     = i_cfg_data;
                    default: ;
                endcase
            end
            // result against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                got        = i_out_item;
                result_seq = result_seq + 1;
                if (mode_outputs_due.size() == 0) begin
                    report_mismatch("with no request pending", got, '0);
                end else begin
                    want = mode_outputs_due.pop_front();
                    if (got.mode !== want.mode || got.drive !== want.drive ||
                        got.status !== want.status ||
                        got.line_error !== want.line_error ||
                        got.steer_reset !== want.steer_reset)
                        report_mismatch("differs", got, want);
                end
            end
            // accepted request: run the mode machine
            if (i_in_valid && i_in_ready) begin
                step_mode_controller(i_in_item, predicted);
                mode_outputs_due.push_back(predicted);
            end
        end
        o_pending    <= mode_outputs_due.size();
        o_mismatches <= bad_count;
    end

endmodule

@@ tb/testbench.sv @@
// top of the line follower mode controller testbench: stimulus, idling and verdict
`timescale 1ns / 1ps
module testbench;
    import lfmc_pkg::*;

    // command code the block must treat as a plain frame
    localparam logic [1:0] KIND_IGNORED  = 2'd3;
    localparam int         LATENCY_SLACK = 8;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_item   out_item;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = CFG_LINE_HOLD;
    logic [15:0] cfg_data  = '0;
    int          mismatches;
    int          pending;

    // timing the block runs with, mirrored to shape the frame timestamps
    int          hold_ms       = RST_LINE_HOLD;
    int          bar_ms        = RST_STOP_BAR;
    int          clr_ms        = RST_CLEAR;
    logic [31:0] now_ms        = '0;
    logic        calm          = 1'b0;
    int          ready_left    = 0;
    int          ready_roll;
    int          requests_sent = 0;

    always #4 clk = ~clk;

    line_follower_mode_controller i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    lfmc_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    // result side: runs of ready and stalls, mostly short, a few long
    always @(posedge clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 65) begin
                out_ready  <= 1'b1;
                ready_left <= $urandom_range(0, 6);
            end else if (ready_roll < 95) begin
                out_ready  <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end else begin
                out_ready  <= 1'b0;
                ready_left <= $urandom_range(15, 50);
            end
        end
    end

    function automatic logic chance(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(15, 50);
    endfunction

    // mostly on the array, sometimes past the last channel
    function automatic logic [11:0] pick_position();
        logic [11:0] pos;
        if (chance(5)) pos = 12'($urandom_range(0, 4095));
        else pos = 12'($urandom_range(0, 4000));
        return pos;
    endfunction

    // commands are rare so that laps get deep into the mode machine
    function automatic logic [1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 59);
        if (roll == 0) return KIND_IDLE;
        if (roll == 1) return KIND_RESUME;
        if (roll == 2) return KIND_IGNORED;
        return KIND_FRAME;
    endfunction

    task automatic advance_clock(input int span);
        now_ms = now_ms + $urandom_range(span / 4, span / 2 + 2);
    endtask

    // present one request and hold it until accepted
    task automatic push_request(input logic [1:0] kind, input logic [31:0] ts,
                                input logic found, input logic [11:0] pos,
                                input logic black, input logic nothing,
                                input logic low);
        int       gap;
        t_in_item req;
        gap               = calm ? 0 : pick_gap();
        req.kind          = kind;
        req.now_ms        = ts;
        req.line_found    = found;
        req.line_position = pos;
        req.all_black     = black;
        req.nothing_seen  = nothing;
        req.supply_low    = low;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (!in_ready);
        requests_sent++;
    endtask

    // stop sending and wait for every result to come back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (LATENCY_SLACK) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] hold, input logic [15:0] bar,
                              input logic [15:0] clr);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LINE_HOLD;
        cfg_data <= hold;
        @(posedge clk);
        cfg_idx  <= CFG_STOP_BAR;
        cfg_data <= bar;
        @(posedge clk);
        cfg_idx  <= CFG_CLEAR;
        cfg_data <= clr;
        @(posedge clk);
        cfg_we  <= 1'b0;
        hold_ms = hold;
        bar_ms  = bar;
        clr_ms  = clr;
    endtask

    // reset timing: every mode, every command, error clamp and each transition
    task automatic directed_checks();
        push_request(KIND_FRAME,   32'd0,    1'b0, 12'd0,    1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd10,   1'b1, 12'd0,    1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd20,   1'b1, 12'd4095, 1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd30,   1'b1, 12'd4000, 1'b0, 1'b0, 1'b1);
        push_request(KIND_IGNORED, 32'd40,   1'b1, 12'd2000, 1'b0, 1'b0, 1'b0);
        push_request(KIND_IDLE,    32'd50,   1'b1, 12'd1,    1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd60,   1'b0, 12'd4095, 1'b1, 1'b1, 1'b1);
        push_request(KIND_RESUME,  32'd70,   1'b1, 12'd2500, 1'b0, 1'b0, 1'b0);
        // line held: start following
        push_request(KIND_FRAME,   32'd270,  1'b1, 12'd2500, 1'b0, 1'b0, 1'b0);
        // bar before arming, then arm, confirm and finish
        push_request(KIND_FRAME,   32'd280,  1'b1, 12'd2000, 1'b1, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd290,  1'b1, 12'd2000, 1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd300,  1'b1, 12'd2000, 1'b1, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd449,  1'b1, 12'd2000, 1'b1, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd450,  1'b1, 12'd2000, 1'b1, 1'b0, 1'b0);
        // brake until the track is clear long enough
        push_request(KIND_FRAME,   32'd460,  1'b0, 12'd0,    1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd470,  1'b0, 12'd0,    1'b0, 1'b1, 1'b0);
        push_request(KIND_FRAME,   32'd970,  1'b0, 12'd0,    1'b0, 1'b1, 1'b0);
        push_request(KIND_FRAME,   32'd980,  1'b1, 12'd4000, 1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'd1180, 1'b1, 12'd4000, 1'b0, 1'b0, 1'b0);
        // manual stop while following, resume, and a wrapped timestamp
        push_request(KIND_IDLE,    32'd1190, 1'b1, 12'd3000, 1'b0, 1'b0, 1'b0);
        push_request(KIND_RESUME,  32'd1200, 1'b1, 12'd0,    1'b0, 1'b0, 1'b0);
        push_request(KIND_FRAME,   32'hFFFF_FFF0, 1'b1, 12'd0, 1'b0, 1'b0, 1'b0);
        push_request(KIND_RESUME,  32'hFFFF_FFFF, 1'b0, 12'd0, 1'b1, 1'b1, 1'b0);
    endtask

    // one pass around the track with random content
    task automatic run_lap();
        int n;
        calm = chance(5);
        if (chance(3)) begin
            advance_clock(8);
            push_request(KIND_RESUME, now_ms, 1'b1, pick_position(), 1'b0, 1'b0, 1'b0);
        end
        // hold a line until the start
        n = $urandom_range(3, 8);
        repeat (n) begin
            advance_clock(hold_ms);
            push_request(pick_kind(), now_ms, !chance(10), pick_position(),
                         chance(10), chance(10), chance(16));
        end
        // sometimes a bar before arming, then line that arms the stop
        if (chance(4)) begin
            advance_clock(40);
            push_request(KIND_FRAME, now_ms, 1'b1, pick_position(), 1'b1, 1'b0, chance(8));
        end
        n = $urandom_range(1, 6);
        repeat (n) begin
            advance_clock(40);
            push_request(pick_kind(), now_ms, !chance(8), pick_position(),
                         chance(8), chance(10), chance(8));
        end
        // stop bar
        n = $urandom_range(2, 7);
        repeat (n) begin
            advance_clock(bar_ms);
            push_request(pick_kind(), now_ms, chance(2), pick_position(),
                         !chance(8), chance(10), chance(8));
        end
        // clear track after the finish
        n = $urandom_range(2, 8);
        repeat (n) begin
            advance_clock(clr_ms);
            push_request(pick_kind(), now_ms, chance(6), pick_position(),
                         chance(10), !chance(8), chance(8));
        end
    endtask

    // a few requests with anything in them, timestamps sometimes jumping anywhere
    task automatic send_noise();
        int n;
        n = $urandom_range(0, 3);
        repeat (n) begin
            if (chance(4)) now_ms = $urandom();
            else advance_clock(hold_ms);
            push_request(2'($urandom_range(0, 3)), now_ms, 1'($urandom_range(0, 1)),
                         12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(input int quota);
        int stop_at;
        stop_at = requests_sent + quota;
        while (requests_sent < stop_at) begin
            run_lap();
            send_noise();
            if (chance(8)) drain_results();
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        directed_checks();
        now_ms = 32'd2000;
        run_phase(200);
        set_config(16'd0, 16'd0, 16'd0);
        run_phase(230);
        now_ms = 32'hFFFF_0000;
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(230);
        set_config(16'd1, 16'hFFFF, 16'd0);
        run_phase(230);
        set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
        run_phase(230);
        set_config(16'($urandom_range(0, 1000)), 16'($urandom_range(0, 1000)),
                   16'($urandom_range(0, 1000)));
        run_phase(230);
        calm = 1'b0;
        drain_results();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
